// File: sv/cfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg - shared types and functions for the crc checked frame receiver
// Event codes, the per-byte result record and the CRC16-XMODEM byte update.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // largest parameter count a frame may carry; longer lengths saturate here
  localparam int unsigned MaxParamBytes = 256;

  localparam logic [7:0]  StartByteReset = 8'd47;
  localparam logic [15:0] CrcPoly        = 16'h1021;

  // output tdata: param_byte, param_index, command_code, target_address, param_count
  localparam int unsigned OutDataW = 56;

  typedef enum logic [1:0] {
    EvParam   = 2'd0,
    EvCrcGood = 2'd1,
    EvCrcBad  = 2'd2
  } event_kind_e;

  // one result item as produced by the parser
  typedef struct packed {
    logic        valid;
    event_kind_e kind;
    logic [7:0]  param_byte;
    logic [7:0]  param_index;
    logic [7:0]  command_code;
    logic [15:0] target_address;
    logic [8:0]  param_count;
  } cfr_result_t;

  // crc16-xmodem, msb first, one byte folded in
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/cfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_parser - frame field parser with running crc
// Walks the frame one byte per transfer and forms the result for that byte.
// ----------------------------------------------------------------------------
module cfr_parser
  import cfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_en_i,     // a byte transfer is taken this cycle
  input  logic [7:0]  byte_i,
  input  logic [7:0]  start_byte_i,
  output cfr_result_t result_o       // result of the byte in this cycle
);

  typedef enum logic [7:0] {
    PhHunt   = 8'b0000_0001,
    PhCmd    = 8'b0000_0010,
    PhAddrHi = 8'b0000_0100,
    PhAddrLo = 8'b0000_1000,
    PhLen    = 8'b0001_0000,
    PhParam  = 8'b0010_0000,
    PhCrcHi  = 8'b0100_0000,
    PhCrcLo  = 8'b1000_0000
  } phase_e;

  localparam logic [8:0] MaxCount = 9'(MaxParamBytes);

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] addr_q, addr_d;
  logic [8:0]  count_q, count_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  crc_hi_q, crc_hi_d;

  logic [15:0] crc_next;
  logic [8:0]  len_count;
  logic        last_param;

  assign crc_next   = crc_fold(crc_q, byte_i);
  assign last_param = ({1'b0, idx_q} + 9'd1) >= count_q;

  // length byte of zero stands for the largest count
  always_comb begin
    len_count = (byte_i == 8'd0) ? 9'd256 : {1'b0, byte_i};
    if (len_count > MaxCount) begin
      len_count = MaxCount;
    end
  end

  // next state and result for the current byte
  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    cmd_d    = cmd_q;
    addr_d   = addr_q;
    count_d  = count_q;
    idx_d    = idx_q;
    crc_hi_d = crc_hi_q;

    result_o                = '0;
    result_o.kind           = EvParam;
    result_o.command_code   = cmd_q;
    result_o.target_address = addr_q;
    result_o.param_count    = count_q;

    unique case (phase_q)
      PhHunt: begin
        crc_d = crc_fold(16'h0000, byte_i);
        if (byte_i == start_byte_i) begin
          phase_d = PhCmd;
        end
      end
      PhCmd: begin
        crc_d   = crc_next;
        cmd_d   = byte_i;
        phase_d = PhAddrHi;
      end
      PhAddrHi: begin
        crc_d   = crc_next;
        addr_d  = {byte_i, 8'h00};
        phase_d = PhAddrLo;
      end
      PhAddrLo: begin
        crc_d   = crc_next;
        addr_d  = {addr_q[15:8], byte_i};
        phase_d = PhLen;
      end
      PhLen: begin
        crc_d   = crc_next;
        count_d = len_count;
        idx_d   = 8'd0;
        phase_d = PhParam;
      end
      PhParam: begin
        crc_d                = crc_next;
        result_o.valid       = 1'b1;
        result_o.kind        = EvParam;
        result_o.param_byte  = byte_i;
        result_o.param_index = idx_q;
        if (last_param) begin
          idx_d   = 8'd0;
          phase_d = PhCrcHi;
        end else begin
          idx_d = idx_q + 8'd1;
        end
      end
      PhCrcHi: begin
        crc_hi_d = byte_i;
        phase_d  = PhCrcLo;
      end
      PhCrcLo: begin
        result_o.valid = 1'b1;
        result_o.kind  = ({crc_hi_q, byte_i} == crc_q) ? EvCrcGood : EvCrcBad;
        phase_d        = PhHunt;
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase

    if (!byte_en_i) begin
      result_o.valid = 1'b0;
    end
  end

  // parser state, advanced only on a byte transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      crc_q    <= '0;
      cmd_q    <= '0;
      addr_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      crc_hi_q <= '0;
    end else if (byte_en_i) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      cmd_q    <= cmd_d;
      addr_q   <= addr_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      crc_hi_q <= crc_hi_d;
    end
  end

endmodule

// File: sv/crc_checked_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver - host frame receiver with crc16-xmodem check
// Parses start, command, address, length, parameters and crc from a byte
// stream; reports each parameter byte and a crc verdict at frame end.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the slave stream and keeps that rate
// for as long as the master side drains results; the result of each byte
// is formed by a single combinational network between the parser state and
// the output register, so a result appears in the cycle after its byte.
// The output register is the only buffer: s_axis_tready drops only while a
// result sits there and m_axis_tready is low. Bytes in the hunt, header and
// crc high phases produce no result. start_byte may be written only while
// the block is idle; it resets to 47.
module crc_checked_frame_receiver
  import cfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,      // start_byte
  // received bytes
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,     // [7:0] rx_byte
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,     // [7:0] param_byte, [15:8] param_index,
                                                // [23:16] command_code,
                                                // [39:24] target_address,
                                                // [48:40] param_count, [55:49] zero
  output logic [1:0]          m_axis_tuser      // [1:0] event_kind
);

  logic [7:0]  start_byte_q;
  logic        in_xfer;
  cfr_result_t res;
  cfr_result_t out_q;

  assign s_axis_tready = !out_q.valid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // start byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteReset;
    end else if (cfg_we_i) begin
      start_byte_q <= cfg_wdata_i;
    end
  end

  cfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_en_i    (in_xfer),
    .byte_i       (s_axis_tdata),
    .start_byte_i (start_byte_q),
    .result_o     (res)
  );

  // output register; reloaded whenever it is free or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (s_axis_tready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_q.valid;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {7'd0, out_q.param_count, out_q.target_address,
                          out_q.command_code, out_q.param_index, out_q.param_byte};

endmodule

// File: sv/cfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_checker - port level checks for the crc checked frame receiver
// Watches the result stream and its handshake; bound to the top level.
// ----------------------------------------------------------------------------
module cfr_checker
  import cfr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  // a stalled result holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  else $error("stalled result changed");

  // only defined event codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == EvParam || m_axis_tuser == EvCrcGood ||
                      m_axis_tuser == EvCrcBad)
  else $error("undefined event kind");

  // parameter index stays inside the frame's count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EvParam |->
      {1'b0, m_axis_tdata[15:8]} < m_axis_tdata[48:40])
  else $error("parameter index beyond count");

  // frame end carries no parameter byte, and the count is in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != EvParam |->
      m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[48:40] != 9'd0 &&
      m_axis_tdata[48:40] <= 9'(MaxParamBytes))
  else $error("bad frame end fields");

  // input may only stall while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
  else $error("input stalled without a held result");

endmodule

bind crc_checked_frame_receiver cfr_checker u_cfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
